### hdl/assert_macros.svh
// Assertion macros used by the checker file fsmcov_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FSMCOV_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("fsmcov assertion failed");

// Condition that must never be seen outside reset.
`define FSMCOV_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("fsmcov forbidden condition seen");

`endif

### hdl/fsmcov_pkg.sv
`default_nettype none

package fsmcov_pkg;

	localparam int NUM_VARS_DEF    = 4;
	localparam int MAX_STATES_DEF  = 16;
	localparam int MAX_TRANS_DEF   = 64;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int          COUNT_WIDTH = 32;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} fsmcov_state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == COUNT_MAX) ? c : c + 32'd1;
	endfunction

endpackage

`default_nettype wire

### hdl/fsmcov_match_unit.sv
`default_nettype none

module fsmcov_match_unit
	import fsmcov_pkg::*;
#(
	parameter int KEY_WIDTH = 2 * VALUE_WIDTH_DEF
) (
	input  wire logic [KEY_WIDTH-1:0]   key_a,
	input  wire logic [KEY_WIDTH-1:0]   key_b,
	input  wire logic [COUNT_WIDTH-1:0] count_in,
	output logic                        equal,
	output logic [COUNT_WIDTH-1:0]      count_next
);

	// The single compare and saturating increment shared by both table searches.
	assign equal      = (key_a == key_b);
	assign count_next = sat_inc(count_in);

endmodule

`default_nettype wire

### hdl/fsm_state_transition_coverage_core.sv
// FSM state and transition coverage collector.
// A sample transaction on the input channel (in_valid, in_ready) carries a
// variable number and its previous and current value. The block searches that
// variable's table of seen states for the current value, then its table of seen
// transition pairs, one table entry per cycle through a single compare and
// increment unit, updating or appending entries as it goes.
// One result transaction per sample leaves on the output channel (out_valid,
// out_ready). in_ready is high only while the block is idle and returns the
// cycle after a result is loaded. A finished result sits in an output
// register, and a new sample may be accepted while the receiver stalls; the
// block then waits at the end of that sample until the register is free.
// Reset clears the fill counts and sample counters; table contents are only
// read below the fill count, so they need no clearing.
`default_nettype none

module fsm_state_transition_coverage_core
	import fsmcov_pkg::*;
#(
	parameter int NUM_VARS    = NUM_VARS_DEF,
	parameter int MAX_STATES  = MAX_STATES_DEF,
	parameter int MAX_TRANS   = MAX_TRANS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  variable_id,
	input  wire logic [15:0] previous_value,
	input  wire logic [15:0] current_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       state_slot,
	output logic [31:0]      state_hits,
	output logic             state_was_new,
	output logic [5:0]       trans_slot,
	output logic [31:0]      trans_hits,
	output logic             trans_was_new,
	output logic [31:0]      sample_total,
	output logic [1:0]       table_full
);

	localparam int VIW   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int SIW   = $clog2(MAX_STATES + 1);
	localparam int TIW   = $clog2(MAX_TRANS + 1);
	localparam int IW    = (SIW > TIW) ? SIW : TIW;
	localparam int SAW   = $clog2(NUM_VARS * MAX_STATES);
	localparam int TAW   = $clog2(NUM_VARS * MAX_TRANS);
	localparam int KW    = 2 * VALUE_WIDTH;
	localparam int SDW   = VALUE_WIDTH + COUNT_WIDTH;
	localparam int TDW   = KW + COUNT_WIDTH;
	localparam int SDEPTH = NUM_VARS * MAX_STATES;
	localparam int TDEPTH = NUM_VARS * MAX_TRANS;

	fsmcov_state_t state_q, state_next;

	logic                   phase_q;
	logic                   id_ok_q;
	logic [1:0]             id_q;
	logic [VALUE_WIDTH-1:0] prev_q;
	logic [VALUE_WIDTH-1:0] cur_q;
	logic [IW-1:0]          idx_q;
	logic                   pend_q;
	logic [IW-1:0]          pend_idx_q;

	logic [3:0]             res_st_slot_q;
	logic [31:0]            res_st_hits_q;
	logic                   res_st_new_q;
	logic [5:0]             res_tr_slot_q;
	logic [31:0]            res_tr_hits_q;
	logic                   res_tr_new_q;
	logic [1:0]             res_full_q;

	logic                   out_valid_q;
	logic [3:0]             out_st_slot_q;
	logic [31:0]            out_st_hits_q;
	logic                   out_st_new_q;
	logic [5:0]             out_tr_slot_q;
	logic [31:0]            out_tr_hits_q;
	logic                   out_tr_new_q;
	logic [31:0]            out_total_q;
	logic [1:0]             out_full_q;

	logic [SIW-1:0]         states_used_q [NUM_VARS];
	logic [TIW-1:0]         trans_used_q  [NUM_VARS];
	logic [31:0]            samples_q     [NUM_VARS];

	logic [SDW-1:0]         st_mem [SDEPTH];
	logic [TDW-1:0]         tr_mem [TDEPTH];
	logic [SDW-1:0]         st_rd_data_q;
	logic [TDW-1:0]         tr_rd_data_q;

	logic                   accept;
	logic                   id_ok_in;
	logic [VIW-1:0]         var_idx;
	logic [IW-1:0]          used_cur;
	logic [IW-1:0]          max_cur;
	logic                   issue;
	logic                   exhausted;
	logic                   room;
	logic                   hit;
	logic                   end_phase;
	logic                   out_free;
	logic                   load_out;
	logic [KW-1:0]          cmp_key_a;
	logic [KW-1:0]          cmp_key_b;
	logic [COUNT_WIDTH-1:0] cnt_in;
	logic                   cmp_equal;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [IW-1:0]          wr_slot;
	logic [COUNT_WIDTH-1:0] wr_cnt;
	logic                   st_wr_en;
	logic                   tr_wr_en;
	logic                   st_rd_en;
	logic                   tr_rd_en;
	logic [SAW-1:0]         st_base;
	logic [TAW-1:0]         tr_base;
	logic [31:0]            total_next;

	assign accept    = in_valid && in_ready;
	assign id_ok_in  = (int'(variable_id) < NUM_VARS);
	assign var_idx   = VIW'(id_q);
	assign used_cur  = phase_q ? IW'(trans_used_q[var_idx]) : IW'(states_used_q[var_idx]);
	assign max_cur   = phase_q ? IW'(MAX_TRANS) : IW'(MAX_STATES);
	assign issue     = (state_q == ST_SCAN) && (idx_q < used_cur);
	assign exhausted = !pend_q && !(idx_q < used_cur);
	assign room      = (used_cur < max_cur);

	assign cmp_key_a = phase_q ? {prev_q, cur_q} : KW'(cur_q);
	assign cmp_key_b = phase_q ? tr_rd_data_q[TDW-1:COUNT_WIDTH]
	                           : KW'(st_rd_data_q[SDW-1:COUNT_WIDTH]);
	assign cnt_in    = phase_q ? tr_rd_data_q[COUNT_WIDTH-1:0]
	                           : st_rd_data_q[COUNT_WIDTH-1:0];

	fsmcov_match_unit #(
		.KEY_WIDTH (KW)
	) u_match (
		.key_a      (cmp_key_a),
		.key_b      (cmp_key_b),
		.count_in   (cnt_in),
		.equal      (cmp_equal),
		.count_next (cnt_inc)
	);

	assign hit       = pend_q && cmp_equal;
	assign end_phase = (state_q == ST_SCAN) && (hit || exhausted);
	assign wr_slot   = hit ? pend_idx_q : used_cur;
	assign wr_cnt    = hit ? cnt_inc : 32'd1;

	assign st_wr_en  = end_phase && !phase_q && (hit || room);
	assign tr_wr_en  = end_phase && phase_q && (hit || room);
	assign st_rd_en  = issue && !phase_q;
	assign tr_rd_en  = issue && phase_q;
	assign st_base   = SAW'(var_idx) * SAW'(MAX_STATES);
	assign tr_base   = TAW'(var_idx) * TAW'(MAX_TRANS);

	assign out_free   = !out_valid_q || out_ready;
	assign load_out   = (state_q == ST_DONE) && out_free;
	assign total_next = sat_inc(samples_q[var_idx]);

	always_ff @(posedge clk) begin
		if (st_wr_en) begin
			st_mem[st_base + SAW'(wr_slot)] <= {cur_q, wr_cnt};
		end
		if (st_rd_en) begin
			st_rd_data_q <= st_mem[st_base + SAW'(idx_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (tr_wr_en) begin
			tr_mem[tr_base + TAW'(wr_slot)] <= {prev_q, cur_q, wr_cnt};
		end
		if (tr_rd_en) begin
			tr_rd_data_q <= tr_mem[tr_base + TAW'(idx_q)];
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = id_ok_in ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (end_phase && phase_q) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			pend_q     <= 1'b0;
			idx_q      <= '0;
			pend_idx_q <= '0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				phase_q <= 1'b0;
				pend_q  <= 1'b0;
				idx_q   <= '0;
			end else if (state_q == ST_SCAN) begin
				if (end_phase) begin
					phase_q <= 1'b1;
					pend_q  <= 1'b0;
					idx_q   <= '0;
				end else begin
					pend_q     <= issue;
					pend_idx_q <= idx_q;
					if (issue) begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q          <= variable_id;
			id_ok_q       <= id_ok_in;
			prev_q        <= VALUE_WIDTH'(previous_value);
			cur_q         <= VALUE_WIDTH'(current_value);
			res_st_slot_q <= '0;
			res_st_hits_q <= '0;
			res_st_new_q  <= 1'b0;
			res_tr_slot_q <= '0;
			res_tr_hits_q <= '0;
			res_tr_new_q  <= 1'b0;
			res_full_q    <= '0;
		end else if (end_phase) begin
			if (hit || room) begin
				if (phase_q) begin
					res_tr_slot_q <= 6'(wr_slot);
					res_tr_hits_q <= wr_cnt;
					res_tr_new_q  <= !hit;
				end else begin
					res_st_slot_q <= 4'(wr_slot);
					res_st_hits_q <= wr_cnt;
					res_st_new_q  <= !hit;
				end
			end else begin
				res_full_q[phase_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VARS; v++) begin
				states_used_q[v] <= '0;
				trans_used_q[v]  <= '0;
				samples_q[v]     <= '0;
			end
		end else begin
			if (end_phase && !hit && room) begin
				if (phase_q) begin
					trans_used_q[var_idx] <= trans_used_q[var_idx] + TIW'(1);
				end else begin
					states_used_q[var_idx] <= states_used_q[var_idx] + SIW'(1);
				end
			end
			if (load_out && id_ok_q) begin
				samples_q[var_idx] <= total_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_st_slot_q <= res_st_slot_q;
			out_st_hits_q <= res_st_hits_q;
			out_st_new_q  <= res_st_new_q;
			out_tr_slot_q <= res_tr_slot_q;
			out_tr_hits_q <= res_tr_hits_q;
			out_tr_new_q  <= res_tr_new_q;
			out_total_q   <= id_ok_q ? total_next : 32'd0;
			out_full_q    <= res_full_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign state_slot    = out_st_slot_q;
	assign state_hits    = out_st_hits_q;
	assign state_was_new = out_st_new_q;
	assign trans_slot    = out_tr_slot_q;
	assign trans_hits    = out_tr_hits_q;
	assign trans_was_new = out_tr_new_q;
	assign sample_total  = out_total_q;
	assign table_full    = out_full_q;

endmodule

`default_nettype wire

### hdl/fsmcov_chk.sv
`default_nettype none

`include "assert_macros.svh"

module fsmcov_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  variable_id,
	input wire logic [15:0] previous_value,
	input wire logic [15:0] current_value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  state_slot,
	input wire logic [31:0] state_hits,
	input wire logic        state_was_new,
	input wire logic [5:0]  trans_slot,
	input wire logic [31:0] trans_hits,
	input wire logic        trans_was_new,
	input wire logic [31:0] sample_total,
	input wire logic [1:0]  table_full
);

	// A result transaction that is held back stays offered.
	`FSMCOV_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// Only one sample is worked on at a time.
	`FSMCOV_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)

	// A newly added state or transition has been counted exactly once.
	`FSMCOV_NEVER(a_new_state_once, clk, arst_n, out_valid && state_was_new && state_hits != 32'd1)
	`FSMCOV_NEVER(a_new_trans_once, clk, arst_n, out_valid && trans_was_new && trans_hits != 32'd1)

	// A dropped state leaves its result fields clear.
	`FSMCOV_NEVER(a_full_state_clear, clk, arst_n, out_valid && table_full[0] && (state_hits != 32'd0 || state_was_new || state_slot != 4'd0))

endmodule

bind fsm_state_transition_coverage_core fsmcov_chk u_fsmcov_chk (.*);

`default_nettype wire

### test/fsm_state_transition_coverage_core_checker.sv
`timescale 1ns / 100ps

module fsm_state_transition_coverage_core_checker
	import fsmcov_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  variable_id,
	input  wire logic [15:0] previous_value,
	input  wire logic [15:0] current_value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [3:0]  state_slot,
	input  wire logic [31:0] state_hits,
	input  wire logic        state_was_new,
	input  wire logic [5:0]  trans_slot,
	input  wire logic [31:0] trans_hits,
	input  wire logic        trans_was_new,
	input  wire logic [31:0] sample_total,
	input  wire logic [1:0]  table_full,
	output int               mismatches,
	output int               outstanding
);

	localparam int VARS   = NUM_VARS_DEF;
	localparam int STATES = MAX_STATES_DEF;
	localparam int TRANS  = MAX_TRANS_DEF;

	typedef struct {
		logic [3:0]  state_slot;
		logic [31:0] state_hits;
		logic        state_was_new;
		logic [5:0]  trans_slot;
		logic [31:0] trans_hits;
		logic        trans_was_new;
		logic [31:0] sample_total;
		logic [1:0]  table_full;
	} coverage_result_t;

	logic [15:0] state_value [VARS][STATES];
	logic [31:0] state_count [VARS][STATES];
	int          states_held [VARS];
	logic [31:0] pair_value  [VARS][TRANS];
	logic [31:0] pair_count  [VARS][TRANS];
	int          pairs_held  [VARS];
	logic [31:0] samples_of  [VARS];

	coverage_result_t pending_results [$];

	// Updates the coverage tables for one sample and returns the result it should produce.
	function automatic coverage_result_t record_sample(input logic [1:0] v,
			input logic [15:0] prev, input logic [15:0] cur);
		coverage_result_t r;
		logic [31:0] pair;
		bit hit;
		int id;
		r = '{default: '0};
		id = v;
		pair = {prev, cur};
		if (id >= VARS) begin
			return r;
		end
		hit = 0;
		for (int i = 0; i < states_held[id] && !hit; i++) begin
			if (state_value[id][i] == cur) begin
				if (state_count[id][i] != COUNT_MAX) begin
					state_count[id][i]++;
				end
				r.state_slot = 4'(i);
				r.state_hits = state_count[id][i];
				hit = 1;
			end
		end
		if (!hit) begin
			if (states_held[id] < STATES) begin
				state_value[id][states_held[id]] = cur;
				state_count[id][states_held[id]] = 32'd1;
				r.state_slot = 4'(states_held[id]);
				r.state_hits = 32'd1;
				r.state_was_new = 1'b1;
				states_held[id]++;
			end else begin
				r.table_full[0] = 1'b1;
			end
		end
		hit = 0;
		for (int i = 0; i < pairs_held[id] && !hit; i++) begin
			if (pair_value[id][i] == pair) begin
				if (pair_count[id][i] != COUNT_MAX) begin
					pair_count[id][i]++;
				end
				r.trans_slot = 6'(i);
				r.trans_hits = pair_count[id][i];
				hit = 1;
			end
		end
		if (!hit) begin
			if (pairs_held[id] < TRANS) begin
				pair_value[id][pairs_held[id]] = pair;
				pair_count[id][pairs_held[id]] = 32'd1;
				r.trans_slot = 6'(pairs_held[id]);
				r.trans_hits = 32'd1;
				r.trans_was_new = 1'b1;
				pairs_held[id]++;
			end else begin
				r.table_full[1] = 1'b1;
			end
		end
		if (samples_of[id] != COUNT_MAX) begin
			samples_of[id]++;
		end
		r.sample_total = samples_of[id];
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		coverage_result_t want;
		coverage_result_t fresh;
		if (!arst_n) begin
			for (int v = 0; v < VARS; v++) begin
				states_held[v] = 0;
				pairs_held[v] = 0;
				samples_of[v] = '0;
			end
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$error("Result transaction arrived with no sample outstanding.");
				end else begin
					want = pending_results.pop_front();
					compare_field("state_slot", want.state_slot, state_slot);
					compare_field("state_hits", want.state_hits, state_hits);
					compare_field("state_was_new", want.state_was_new, state_was_new);
					compare_field("trans_slot", want.trans_slot, trans_slot);
					compare_field("trans_hits", want.trans_hits, trans_hits);
					compare_field("trans_was_new", want.trans_was_new, trans_was_new);
					compare_field("sample_total", want.sample_total, sample_total);
					compare_field("table_full", want.table_full, table_full);
				end
			end
			if (in_valid && in_ready) begin
				fresh = record_sample(variable_id, previous_value, current_value);
				pending_results.insert(pending_results.size(), fresh);
			end
		end
		outstanding = pending_results.size();
	end

endmodule

### test/fsm_state_transition_coverage_core_test.sv
`timescale 1ns / 100ps

module fsm_state_transition_coverage_core_test;
	import fsmcov_pkg::*;

	localparam int POOL_SIZE      = 20;
	localparam int TRACE_ITEMS    = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  variable_id;
	logic [15:0] previous_value;
	logic [15:0] current_value;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  state_slot;
	logic [31:0] state_hits;
	logic        state_was_new;
	logic [5:0]  trans_slot;
	logic [31:0] trans_hits;
	logic        trans_was_new;
	logic [31:0] sample_total;
	logic [1:0]  table_full;

	int          mismatches;
	int          outstanding;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles = 0;
	logic        in_fire = 1'b0;
	logic [15:0] value_pool [4][POOL_SIZE];
	logic [15:0] last_value [4];

	fsm_state_transition_coverage_core uut (.*);

	fsm_state_transition_coverage_core_checker coverage_check (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The transaction is withdrawn once accepted; the block stays busy while it works on the sample.
	task automatic send_sample(input logic [1:0] v, input logic [15:0] prev, input logic [15:0] cur);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		variable_id <= v;
		previous_value <= prev;
		current_value <= cur;
		@(negedge clk);
		while (!in_fire) begin
			@(negedge clk);
		end
		in_valid <= 1'b0;
		last_value[v] = cur;
		@(negedge clk);
	endtask

	task automatic await_drain();
		in_valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	// Mostly follows each variable's own trace through a small set of values, so that
	// states and transitions recur; the remainder are broken traces and pure noise.
	task automatic run_trace(input int count);
		logic [1:0] v;
		logic [15:0] prev;
		logic [15:0] cur;
		int roll;
		repeat (count) begin
			v = 2'($urandom_range(0, 3));
			roll = $urandom_range(0, 99);
			cur = value_pool[v][($urandom_range(0, 3) == 0) ?
				$urandom_range(0, POOL_SIZE - 1) : $urandom_range(0, 7)];
			if (roll < 80) begin
				prev = last_value[v];
			end else if (roll < 90) begin
				prev = value_pool[v][$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				prev = 16'($urandom);
				cur = 16'($urandom);
			end
			send_sample(v, prev, cur);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		variable_id = '0;
		previous_value = '0;
		current_value = '0;
		out_ready = 1'b0;
		send_idle_pct = 36;
		recv_idle_pct = 76;
		for (int v = 0; v < 4; v++) begin
			last_value[v] = '0;
			for (int k = 0; k < POOL_SIZE; k++) begin
				value_pool[v][k] = 16'($urandom);
			end
			value_pool[v][0] = 16'h0000;
			value_pool[v][1] = 16'hFFFF;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(2'd0, 16'h0000, 16'h0000);
		send_sample(2'd0, 16'h0000, 16'h0000);
		send_sample(2'd0, 16'h0000, 16'hFFFF);
		send_sample(2'd0, 16'hFFFF, 16'hFFFF);
		send_sample(2'd0, 16'hFFFF, 16'h0000);
		send_sample(2'd0, 16'hFFFF, 16'hFFFF);
		send_sample(2'd1, 16'h5555, 16'hAAAA);
		send_sample(2'd1, 16'hAAAA, 16'h5555);
		// One more distinct state than the table holds, so the last one is dropped.
		for (int k = 0; k <= MAX_STATES_DEF; k++) begin
			send_sample(2'd3, 16'(k * 4099), 16'((k + 1) * 4099));
		end

		run_trace(TRACE_ITEMS);
		await_drain();
		send_idle_pct = 76;
		recv_idle_pct = 36;
		run_trace(TRACE_ITEMS);
		await_drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_trace(TRACE_ITEMS);
		await_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/fsmcov_pkg.sv
hdl/fsmcov_match_unit.sv
hdl/fsm_state_transition_coverage_core.sv
hdl/fsmcov_chk.sv
test/fsm_state_transition_coverage_core_checker.sv
test/fsm_state_transition_coverage_core_test.sv
